[hw/rtl/sts_pkg.sv]
// Shared types and constants for the S-expression token scanner.
package sts_pkg;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_WORD = 2'd1;
	localparam logic [1:0] MODE_STR  = 2'd2;
	localparam logic [1:0] MODE_ESC  = 2'd3;

	localparam logic [1:0] KIND_STRING = 2'd0;
	localparam logic [1:0] KIND_INT    = 2'd1;
	localparam logic [1:0] KIND_SYMBOL = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	localparam logic [35:0] LIMIT_POS = 36'h07FFFFFFF;
	localparam logic [35:0] LIMIT_NEG = 36'h080000000;

	typedef struct packed {
		logic       is_space;
		logic       is_quote;
		logic       is_bslash;
		logic       is_minus;
		logic       is_digit;
		logic [3:0] digit;
	} sts_class_t;

	typedef struct packed {
		sts_class_t cls;
		logic [31:0] pos;
	} sts_entry_t;

endpackage

[hw/rtl/sts_front.sv]
// Front end: byte classification and stream position tracking.
module sts_front import sts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] ch,
	input  logic       q_full,
	output logic       push,
	output sts_entry_t entry
);

	logic [31:0] byte_pos_q;
	logic [7:0]  dig_off;

	assign push    = in_valid && !q_full;
	assign dig_off = ch - CH_ZERO;

	always_comb begin
		entry.cls.is_space  = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL);
		entry.cls.is_quote  = (ch == CH_QUOTE);
		entry.cls.is_bslash = (ch == CH_BSLASH);
		entry.cls.is_minus  = (ch == CH_MINUS);
		entry.cls.is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
		entry.cls.digit     = dig_off[3:0];
		entry.pos           = byte_pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
		end else if (push) begin
			byte_pos_q <= byte_pos_q + 32'd1;
		end
	end

endmodule

[hw/rtl/sts_fifo.sv]
// Short queue of classified words between front and back.
module sts_fifo import sts_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  sts_entry_t wr_entry,
	input  logic       pop,
	output sts_entry_t rd_entry,
	output logic       empty,
	output logic       full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sts_entry_t     mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(DEPTH));
	assign rd_entry = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		ptr_next = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count above depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");

endmodule

[hw/rtl/sts_back.sv]
// Back end: token state machine, integer accumulation and result register.
module sts_back import sts_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  sts_entry_t         q_entry,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic [15:0]        length,
	output logic signed [31:0] value,
	output logic [31:0]        start_pos
);

	logic [1:0]  mode_q;
	logic [15:0] len_q;
	logic [31:0] mag_q;
	logic        num_q;
	logic        neg_q;
	logic        ovf_q;
	logic [31:0] tstart_q;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [15:0] length_q;
	logic [31:0] value_q;
	logic [31:0] start_q;

	sts_class_t  c;
	logic        emit;
	logic        out_free;
	logic        load;
	logic [15:0] len_inc;
	logic [35:0] next_mag;
	logic [35:0] limit;
	logic [1:0]  emit_kind;
	logic [31:0] emit_val;

	assign c        = q_entry.cls;
	assign out_free = !out_valid_q || !out_stall;
	assign emit     = ((mode_q == MODE_WORD) && c.is_space)
	                || ((mode_q == MODE_STR) && c.is_quote);
	// Take a word that makes no result even while the output is held.
	assign pop      = !q_empty && (!emit || out_free);
	assign load     = pop && emit;

	assign len_inc  = (len_q != LEN_MAX) ? len_q + 16'd1 : len_q;
	assign next_mag = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + {32'd0, c.digit};
	assign limit    = neg_q ? LIMIT_NEG : LIMIT_POS;

	always_comb begin
		emit_val = 32'd0;
		if (mode_q == MODE_STR) begin
			emit_kind = KIND_STRING;
		end else if (!num_q) begin
			emit_kind = KIND_SYMBOL;
		end else if ((neg_q && len_q == 16'd1) || ovf_q) begin
			emit_kind = KIND_REJECT;
		end else begin
			emit_kind = KIND_INT;
			emit_val  = neg_q ? 32'd0 - mag_q : mag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			len_q    <= '0;
			mag_q    <= '0;
			num_q    <= 1'b0;
			neg_q    <= 1'b0;
			ovf_q    <= 1'b0;
			tstart_q <= '0;
		end else if (pop) begin
			case (mode_q)
				MODE_IDLE: begin
					if (!c.is_space) begin
						tstart_q <= q_entry.pos;
						ovf_q    <= 1'b0;
						if (c.is_quote) begin
							mode_q <= MODE_STR;
							len_q  <= '0;
							num_q  <= 1'b0;
							neg_q  <= 1'b0;
							mag_q  <= '0;
						end else begin
							mode_q <= MODE_WORD;
							len_q  <= 16'd1;
							neg_q  <= c.is_minus;
							num_q  <= c.is_minus || c.is_digit;
							mag_q  <= c.is_digit ? {28'd0, c.digit} : 32'd0;
						end
					end
				end
				MODE_WORD: begin
					if (c.is_space) begin
						mode_q <= MODE_IDLE;
					end else begin
						len_q <= len_inc;
						if (num_q) begin
							if (!c.is_digit) begin
								num_q <= 1'b0;
							end else if (!ovf_q) begin
								// Latch overflow and hold the last in-range magnitude.
								if (next_mag > limit) ovf_q <= 1'b1;
								else                  mag_q <= next_mag[31:0];
							end
						end
					end
				end
				MODE_STR: begin
					if (c.is_quote) begin
						mode_q <= MODE_IDLE;
					end else begin
						len_q <= len_inc;
						if (c.is_bslash) mode_q <= MODE_ESC;
					end
				end
				default: begin
					len_q  <= len_inc;
					mode_q <= MODE_STR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= emit_kind;
			length_q <= len_q;
			value_q  <= emit_val;
			start_q  <= tstart_q;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign length    = length_q;
	assign value     = value_q;
	assign start_pos = start_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !(out_valid_q && out_stall)) else $error("result overwritten while held");
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> mode_q == MODE_IDLE) else $error("scanner not idle after token");
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q != KIND_INT) |-> value_q == 32'd0)
		else $error("nonzero value on non-integer token");

endmodule

[hw/rtl/sexpr_token_scanner.sv]
// Top level of the S-expression token scanner: front, queue and back.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  input   | in_valid, in_stall, ch               | byte in
//  output  | out_valid, out_stall, kind, length,  | token out
//          | value, start_pos                     |
//
// One byte word per cycle sustained while in_stall is low; each byte passes
// the front and the queue and is consumed by the back at once when it makes no token.
// A byte that closes a token waits in the queue while the result register
// is held; the queue of Q_DEPTH words keeps input flowing meanwhile.
// Reset clears position, scanner state and valid flags; no clearing pass.
// A closing byte passes the queue; its token loads the result register when the back pops it.
module sexpr_token_scanner import sts_pkg::*; #(
	parameter int Q_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         ch,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic [15:0]        length,
	output logic signed [31:0] value,
	output logic [31:0]        start_pos
);

	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_empty;
	sts_entry_t wr_entry;
	sts_entry_t rd_entry;

	assign in_stall = q_full;

	sts_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.ch       (ch),
		.q_full   (q_full),
		.push     (push),
		.entry    (wr_entry)
	);

	sts_fifo #(
		.DEPTH (Q_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.empty    (q_empty),
		.full     (q_full)
	);

	sts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_entry   (rd_entry),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.length    (length),
		.value     (value),
		.start_pos (start_pos)
	);

endmodule
